// File: hw/rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Types, opcode constants and helper functions for the script tokenizer.
// ----------------------------------------------------------------------------
package stc_pkg;

	typedef enum logic [2:0] {
		KIND_OPCODE   = 3'd0,
		KIND_PUSH_LEN = 3'd1,
		KIND_EXT_LEN  = 3'd2,
		KIND_DATA     = 3'd3,
		KIND_INVALID  = 3'd4
	} token_kind_t;

	typedef enum logic [2:0] {
		TMPL_NONE     = 3'd0,
		TMPL_P2PKH    = 3'd1,
		TMPL_P2SH     = 3'd2,
		TMPL_P2PK     = 3'd3,
		TMPL_MULTISIG = 3'd4
	} template_t;

	localparam logic [7:0] DIRECT_MIN        = 8'h01;
	localparam logic [7:0] DIRECT_MAX        = 8'h4b;
	localparam logic [7:0] OPC_PUSHDATA1     = 8'h4c;
	localparam logic [7:0] OPC_PUSHDATA2     = 8'h4d;
	localparam logic [7:0] OPC_PUSHDATA4     = 8'h4e;
	localparam logic [7:0] LAST_KNOWN        = 8'hb9;
	localparam logic [7:0] INVALID_OP        = 8'hff;
	localparam logic [7:0] HASH_PUSH         = 8'h14;
	localparam logic [7:0] SMALLINT_BASE     = 8'h50;
	localparam logic [7:0] KEY_LONG          = 8'd65;
	localparam logic [7:0] KEY_SHORT         = 8'd33;
	localparam logic [7:0] OPC_DUP           = 8'h76;
	localparam logic [7:0] OPC_HASH160       = 8'ha9;
	localparam logic [7:0] OPC_EQUAL         = 8'h87;
	localparam logic [7:0] OPC_EQUALVERIFY   = 8'h88;
	localparam logic [7:0] OPC_CHECKSIG      = 8'hac;
	localparam logic [7:0] OPC_CHECKMULTISIG = 8'hae;

	localparam int CAND_PKH = 0;
	localparam int CAND_SH  = 1;
	localparam int CAND_PK  = 2;
	localparam int CAND_MS  = 3;

	// one tagged byte travelling from front to back
	typedef struct packed {
		logic [7:0]  value;
		token_kind_t kind;
		logic        stmt_start;
		logic        stmt_end;
		logic        truncated;
		logic        last;
		logic [7:0]  sym;
	} token_t;

	function automatic logic is_key_push(input logic [7:0] s);
		return (s == KEY_LONG) || (s == KEY_SHORT);
	endfunction

	function automatic logic is_small_int(input logic [7:0] s);
		return (s > SMALLINT_BASE) && (s <= SMALLINT_BASE + 8'd16);
	endfunction

	function automatic logic [7:0] pkh_sym(input logic [2:0] idx);
		logic [7:0] s;
		unique case (idx)
			3'd0: s = OPC_DUP;
			3'd1: s = OPC_HASH160;
			3'd2: s = HASH_PUSH;
			3'd3: s = OPC_EQUALVERIFY;
			3'd4: s = OPC_CHECKSIG;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] sh_sym(input logic [1:0] idx);
		logic [7:0] s;
		unique case (idx)
			2'd0: s = OPC_HASH160;
			2'd1: s = HASH_PUSH;
			2'd2: s = OPC_EQUAL;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// File: hw/rtl/stc_if.sv
// ----------------------------------------------------------------------------
// stc_if
// Stream interfaces for script bytes in and tagged tokens out.
// ----------------------------------------------------------------------------
interface stc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] script_byte;
	logic       end_of_script;

	modport source (output valid, output script_byte, output end_of_script, input ready);
	modport sink (input valid, input script_byte, input end_of_script, output ready);
endinterface

interface stc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_value;
	logic [2:0] token_kind;
	logic       statement_start;
	logic       statement_end;
	logic       truncated;
	logic       script_end;
	logic [2:0] script_template;

	modport source (
		output valid, output token_value, output token_kind, output statement_start,
		output statement_end, output truncated, output script_end,
		output script_template, input ready
	);
	modport sink (
		input valid, input token_value, input token_kind, input statement_start,
		input statement_end, input truncated, input script_end,
		input script_template, output ready
	);
endinterface

// File: hw/rtl/stc_front.sv
// ----------------------------------------------------------------------------
// stc_front
// Byte parser: tracks push lengths and data, tags each beat, flags truncation.
// ----------------------------------------------------------------------------
module stc_front (
	input  logic           clk,
	input  logic           arst_n,
	stc_in_if.sink         script,
	output logic           tok_valid,
	output stc_pkg::token_t tok,
	input  logic           tok_ready
);
	import stc_pkg::*;

	typedef enum logic [2:0] {
		PH_OP   = 3'd0,
		PH_LEN1 = 3'd1,
		PH_LEN2 = 3'd2,
		PH_LEN4 = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [2:0]  len_left_q, len_left_n;
	logic [31:0] len_acc_q, len_acc_n;
	logic [31:0] data_left_q, data_left_n;
	logic [6:0]  push_size_q, push_size_n;

	logic [7:0]  b;
	logic        accept;
	logic [2:0]  total;
	logic [2:0]  left;
	logic [2:0]  left_m1;
	logic [1:0]  pos;
	logic [31:0] data_dec;

	assign b             = script.script_byte;
	assign script.ready  = tok_ready;
	assign tok_valid     = script.valid;
	assign accept        = script.valid & tok_ready;

	always_comb begin
		phase_n       = phase_q;
		len_left_n    = len_left_q;
		len_acc_n     = len_acc_q;
		data_left_n   = data_left_q;
		push_size_n   = push_size_q;
		tok.value     = b;
		tok.kind      = KIND_OPCODE;
		tok.stmt_start = 1'b0;
		tok.stmt_end  = 1'b0;
		tok.sym       = b;
		total         = 3'd4;
		left          = 3'd0;
		left_m1       = 3'd0;
		pos           = 2'd0;
		data_dec      = 32'd0;

		unique case (phase_q)
			PH_LEN1, PH_LEN2, PH_LEN4: begin
				tok.kind = KIND_EXT_LEN;
				total    = (phase_q == PH_LEN1) ? 3'd1 : (phase_q == PH_LEN2) ? 3'd2 : 3'd4;
				left     = len_left_q;
				if (left == 3'd0 || left > total) begin
					left = total;
				end
				pos        = 2'(total - left);
				len_acc_n  = len_acc_q | ({24'd0, b} << {pos, 3'b000});
				left_m1    = left - 3'd1;
				len_left_n = left_m1;
				if (left_m1 == 3'd0) begin
					data_left_n = len_acc_n;
					if (len_acc_n == 32'd0) begin
						tok.stmt_end = 1'b1;
						tok.sym      = OPC_PUSHDATA1;
						phase_n      = PH_OP;
					end else begin
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				tok.kind    = KIND_DATA;
				data_dec    = (data_left_q != 32'd0) ? data_left_q - 32'd1 : 32'd0;
				data_left_n = data_dec;
				if (data_dec == 32'd0) begin
					tok.stmt_end = 1'b1;
					tok.sym      = (push_size_q != 7'd0) ? {1'b0, push_size_q} : OPC_PUSHDATA1;
					phase_n      = PH_OP;
				end
			end
			default: begin
				tok.stmt_start = 1'b1;
				phase_n        = PH_OP;
				if (b >= DIRECT_MIN && b <= DIRECT_MAX) begin
					tok.kind    = KIND_PUSH_LEN;
					push_size_n = b[6:0];
					data_left_n = {24'd0, b};
					phase_n     = PH_DATA;
				end else if (b >= OPC_PUSHDATA1 && b <= OPC_PUSHDATA4) begin
					push_size_n = 7'd0;
					len_acc_n   = 32'd0;
					if (b == OPC_PUSHDATA1) begin
						phase_n    = PH_LEN1;
						len_left_n = 3'd1;
					end else if (b == OPC_PUSHDATA2) begin
						phase_n    = PH_LEN2;
						len_left_n = 3'd2;
					end else begin
						phase_n    = PH_LEN4;
						len_left_n = 3'd4;
					end
				end else if (b <= LAST_KNOWN) begin
					tok.stmt_end = 1'b1;
				end else begin
					tok.value    = INVALID_OP;
					tok.kind     = KIND_INVALID;
					tok.stmt_end = 1'b1;
					tok.sym      = INVALID_OP;
				end
			end
		endcase

		tok.last      = script.end_of_script;
		tok.truncated = script.end_of_script && (phase_n != PH_OP);
		if (script.end_of_script) begin
			phase_n     = PH_OP;
			len_left_n  = 3'd0;
			len_acc_n   = 32'd0;
			data_left_n = 32'd0;
			push_size_n = 7'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OP;
			len_left_q  <= 3'd0;
			len_acc_q   <= 32'd0;
			data_left_q <= 32'd0;
			push_size_q <= 7'd0;
		end else if (accept) begin
			phase_q     <= phase_n;
			len_left_q  <= len_left_n;
			len_acc_q   <= len_acc_n;
			data_left_q <= data_left_n;
			push_size_q <= push_size_n;
		end
	end

endmodule

// File: hw/rtl/stc_queue.sv
// ----------------------------------------------------------------------------
// stc_queue
// Small register FIFO of tokens between parser and classifier.
// ----------------------------------------------------------------------------
module stc_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  stc_pkg::token_t push_tok,
	output logic            push_ready,
	output logic            pop_valid,
	output stc_pkg::token_t pop_tok,
	input  logic            pop_ready
);
	import stc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	token_t           slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_tok    = slots_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/stc_back.sv
// ----------------------------------------------------------------------------
// stc_back
// Statement tracker and template classifier with registered token output.
// ----------------------------------------------------------------------------
module stc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  stc_pkg::token_t in_tok,
	output logic            in_ready,
	stc_out_if.source       token
);
	import stc_pkg::*;

	logic [5:0]  count_q, count_n;
	logic [3:0]  cand_q, cand_n;
	logic [7:0]  first_q, first_n;
	logic [4:0]  keys_q, keys_n;
	logic [15:0] recent_q, recent_n;

	logic        out_valid_q;
	logic        pop;
	logic [7:0]  sym;
	logic [7:0]  last_sym;
	logic [7:0]  prev_sym;
	logic        ms_ok;
	template_t   tmpl;

	assign in_ready = !out_valid_q || token.ready;
	assign pop      = in_valid && in_ready;
	assign sym      = in_tok.sym;

	always_comb begin
		count_n  = count_q;
		cand_n   = cand_q;
		first_n  = first_q;
		keys_n   = keys_q;
		recent_n = recent_q;

		if (in_tok.stmt_end) begin
			if (count_q >= 6'd5 || pkh_sym(count_q[2:0]) != sym) begin
				cand_n[CAND_PKH] = 1'b0;
			end
			if (count_q >= 6'd3 || sh_sym(count_q[1:0]) != sym) begin
				cand_n[CAND_SH] = 1'b0;
			end
			if (!((count_q == 6'd0 && is_key_push(sym)) ||
			      (count_q == 6'd1 && sym == OPC_CHECKSIG))) begin
				cand_n[CAND_PK] = 1'b0;
			end
			if (count_q == 6'd0) begin
				first_n = sym;
				if (!is_small_int(sym)) begin
					cand_n[CAND_MS] = 1'b0;
				end
			end else if (is_key_push(sym) && keys_q != 5'd31) begin
				keys_n = keys_q + 5'd1;
			end
			recent_n = {recent_q[7:0], sym};
			if (count_q != 6'd63) begin
				count_n = count_q + 6'd1;
			end
		end

		last_sym = recent_n[7:0];
		prev_sym = recent_n[15:8];
		ms_ok = cand_n[CAND_MS] && count_n >= 6'd4 && last_sym == OPC_CHECKMULTISIG &&
		        is_small_int(prev_sym) && first_n <= prev_sym &&
		        {3'd0, keys_n} == prev_sym - SMALLINT_BASE &&
		        count_n == {1'b0, keys_n} + 6'd3;

		priority if (in_tok.truncated) begin
			tmpl = TMPL_NONE;
		end else if (cand_n[CAND_PKH] && count_n == 6'd5) begin
			tmpl = TMPL_P2PKH;
		end else if (cand_n[CAND_SH] && count_n == 6'd3) begin
			tmpl = TMPL_P2SH;
		end else if (cand_n[CAND_PK] && count_n == 6'd2) begin
			tmpl = TMPL_P2PK;
		end else if (ms_ok) begin
			tmpl = TMPL_MULTISIG;
		end else begin
			tmpl = TMPL_NONE;
		end

		if (in_tok.last) begin
			count_n  = 6'd0;
			cand_n   = 4'hf;
			first_n  = 8'd0;
			keys_n   = 5'd0;
			recent_n = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= 6'd0;
			cand_q      <= 4'hf;
			first_q     <= 8'd0;
			keys_q      <= 5'd0;
			recent_q    <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				count_q  <= count_n;
				cand_q   <= cand_n;
				first_q  <= first_n;
				keys_q   <= keys_n;
				recent_q <= recent_n;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			token.token_value     <= in_tok.value;
			token.token_kind      <= in_tok.kind;
			token.statement_start <= in_tok.stmt_start;
			token.statement_end   <= in_tok.stmt_end;
			token.truncated       <= in_tok.truncated;
			token.script_end      <= in_tok.last;
			token.script_template <= in_tok.last ? tmpl : TMPL_NONE;
		end
	end

	assign token.valid = out_valid_q;

endmodule

// File: hw/rtl/script_tokenizer_classifier.sv
// ----------------------------------------------------------------------------
// script_tokenizer_classifier
// Splits a byte-serial script into statements, tags every byte and
// classifies the complete script at its end byte.
//
//   channel  dir  payload                                   beat
//   script   in   script_byte, end_of_script                one script byte
//   token    out  token_value, token_kind, statement_start,  one tagged byte
//                 statement_end, truncated, script_end,
//                 script_template
//
// One byte per cycle sustained while the queue has room; a byte taken is written
// into the queue (by the parser), then into the output register (by the classifier).
// The queue of QUEUE_DEPTH beats lets the parser keep taking bytes while
// the output is stalled. Reset clears parser, classifier and queue at once;
// bytes are taken as soon as reset is released.
// ----------------------------------------------------------------------------
module script_tokenizer_classifier #(
	parameter int QUEUE_DEPTH = 4
) (
	input logic       clk,
	input logic       arst_n,
	stc_in_if.sink    script,
	stc_out_if.source token
);
	import stc_pkg::*;

	logic   fr_valid;
	logic   fr_ready;
	token_t fr_tok;
	logic   bk_valid;
	logic   bk_ready;
	token_t bk_tok;

	stc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.script   (script),
		.tok_valid(fr_valid),
		.tok      (fr_tok),
		.tok_ready(fr_ready)
	);

	stc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fr_valid),
		.push_tok  (fr_tok),
		.push_ready(fr_ready),
		.pop_valid (bk_valid),
		.pop_tok   (bk_tok),
		.pop_ready (bk_ready)
	);

	stc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(bk_valid),
		.in_tok  (bk_tok),
		.in_ready(bk_ready),
		.token   (token)
	);

endmodule

// File: hw/rtl/stc_checker.sv
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks on the token stream of the script tokenizer.
// ----------------------------------------------------------------------------
module stc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_value,
	input logic [2:0] out_kind,
	input logic       out_start,
	input logic       out_end,
	input logic       out_trunc,
	input logic       out_last,
	input logic [2:0] out_tmpl
);
	import stc_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_kind) &&
		$stable(out_last) && $stable(out_tmpl))
		else $error("token beat changed while stalled");

	a_tmpl_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_tmpl != TMPL_NONE |-> out_last && !out_trunc)
		else $error("template reported off a clean script end");

	a_trunc_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_trunc |-> out_last && !out_end)
		else $error("truncation flagged on a non-final or completing beat");

	a_start_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_DATA || out_kind == KIND_EXT_LEN) |-> !out_start)
		else $error("statement start on a data or length byte");

	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_INVALID |-> out_value == INVALID_OP && out_start && out_end)
		else $error("invalid opcode beat malformed");

endmodule

bind script_tokenizer_classifier stc_checker u_stc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(token.valid),
	.out_ready(token.ready),
	.out_value(token.token_value),
	.out_kind (token.token_kind),
	.out_start(token.statement_start),
	.out_end  (token.statement_end),
	.out_trunc(token.truncated),
	.out_last (token.script_end),
	.out_tmpl (token.script_template)
);
